### rtl/mrpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_pkg: shared types and constants for the Miller-Rabin primality core
// Holds the base table, the sequencer state type and the multiplier handshake.
// ----------------------------------------------------------------------------
package mrpt_pkg;

    localparam int MaxBases = 10;
    localparam int BaseW    = 5;
    localparam int CountW   = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIAL,
        ST_TRIAL_WAIT,
        ST_SPLIT,
        ST_BASE,
        ST_BASE_WAIT,
        ST_POW,
        ST_POW_WAIT,
        ST_CHECK,
        ST_SQ,
        ST_SQ_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic mode_mod;  // 1: reduce a (a mod n) only, 0: a*b mod n
    } mm_ctl_t;

    function automatic logic [BaseW-1:0] prime_base(input logic [CountW-1:0] idx);
        logic [BaseW-1:0] r;
        begin
            case (idx)
                4'd0:    r = 5'd2;
                4'd1:    r = 5'd3;
                4'd2:    r = 5'd5;
                4'd3:    r = 5'd7;
                4'd4:    r = 5'd11;
                4'd5:    r = 5'd13;
                4'd6:    r = 5'd17;
                4'd7:    r = 5'd19;
                4'd8:    r = 5'd23;
                4'd9:    r = 5'd29;
                default: r = 5'd2;
            endcase
            return r;
        end
    endfunction

endpackage

### rtl/mrpt_modmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_modmul: bit-serial modular multiplier
// Computes a*b mod n one bit of b per cycle (interleaved add/reduce), or
// a mod n by running with multiplicand 1 and a fed bitwise as b.
// ----------------------------------------------------------------------------
module mrpt_modmul
    import mrpt_pkg::*;
#(
    parameter int W = 31
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  mm_ctl_t      ctl,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] n,
    output logic         done,
    output logic [W-1:0] result
);

    localparam int CntW = $clog2(W + 1);

    logic [W-1:0]    acc_reg, acc_next;
    logic [W-1:0]    a_reg, a_next;
    logic [W-1:0]    b_reg, b_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    logic [W+1:0] dbl;
    logic [W+1:0] dbl_red;
    logic [W+1:0] sum;

    // One step: acc = 2*acc (+ a if bit) mod n, MSB first over b.
    // For a-reduction, a is fed bitwise as b with multiplicand 1.
    always_comb
    begin
        dbl = {1'b0, acc_reg, 1'b0};
        dbl_red = (dbl >= {2'b00, n}) ? dbl - {2'b00, n} : dbl;
        sum = dbl_red + (b_reg[W-1] ? {2'b00, a_reg} : '0);
        if (sum >= {2'b00, n})
        begin
            sum = sum - {2'b00, n};
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            acc_next  = '0;
            busy_next = 1'b1;
            cnt_next  = CntW'(W);
            if (ctl.mode_mod)
            begin
                a_next = W'(1);
                b_next = a;
            end
            else
            begin
                a_next = a;
                b_next = b;
            end
        end
        else if (busy_reg)
        begin
            acc_next = sum[W-1:0];
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Note: a < n assumed in multiply mode; in reduce mode a_reg = 1 < n for n >= 2.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

### rtl/miller_rabin_primality_test_core.sv
`timescale 1ns / 1ps
// Cost: each modular multiply runs through a start, one step per operand bit and
// done on the single bit-serial multiplier; a word needs up to 10 trial
// reductions plus, per base, at most about 2*W+1 multiplies.
// Throughput: one word at a time; the next is taken after the result leaves.
// Reset: asynchronous active low; base_count returns to 10, sequencer idles.
// ----------------------------------------------------------------------------
// miller_rabin_primality_test_core: deterministic Miller-Rabin test
// Trial division and witness rounds over the first base_count small primes, capped at 10.
// ----------------------------------------------------------------------------
module miller_rabin_primality_test_core
    import mrpt_pkg::*;
#(
    parameter int NUMBER_WIDTH = 31
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CountW-1:0]       cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [NUMBER_WIDTH-1:0] number,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    is_prime
);

    localparam int W  = NUMBER_WIDTH;
    localparam int VW = $clog2(W + 1);

    state_t state_reg, state_next;

    logic [CountW-1:0] base_count_reg;
    logic [CountW-1:0] count_reg, count_next;
    logic [CountW-1:0] idx_reg, idx_next;
    logic [W-1:0]      n_reg, n_next;
    logic [W-1:0]      u_reg, u_next;
    logic [VW-1:0]     v_reg, v_next;
    logic [W-1:0]      e_reg, e_next;
    logic [W-1:0]      m_reg, m_next;
    logic [W-1:0]      s_reg, s_next;
    logic [VW-1:0]     k_reg, k_next;
    logic              phase_reg, phase_next;  // pow: 0 multiply m, 1 square s
    logic              res_reg, res_next;
    logic              ov_reg, ov_next;

    mm_ctl_t      mm_ctl;
    logic [W-1:0] mm_a, mm_b;
    logic [W-1:0] mm_n;
    logic         mm_done;
    logic [W-1:0] mm_res;

    logic [W-1:0] base_w;
    logic [W-1:0] n_m1;

    assign base_w = W'(prime_base(idx_reg));
    assign n_m1   = n_reg - 1'b1;

    mrpt_modmul #(.W(W)) u_mm (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mm_ctl),
        .a      (mm_a),
        .b      (mm_b),
        .n      (mm_n),
        .done   (mm_done),
        .result (mm_res)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_count_reg <= CountW'(MaxBases);
        end
        else if (cfg_we)
        begin
            base_count_reg <= cfg_wdata;
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = ST_TRIAL;
                end
            end
            ST_TRIAL:
            begin
                if (n_reg < W'(2))
                    state_next = ST_DONE;
                else if (idx_reg >= count_reg)
                    state_next = ST_SPLIT;
                else if (n_reg == base_w)
                    state_next = ST_DONE;
                else
                    state_next = ST_TRIAL_WAIT;
            end
            ST_TRIAL_WAIT:
            begin
                if (mm_done)
                    state_next = (mm_res == '0) ? ST_DONE : ST_TRIAL;
            end
            ST_SPLIT:
            begin
                if (u_reg[0])
                    state_next = ST_BASE;
            end
            ST_BASE:
            begin
                state_next = (idx_reg >= count_reg) ? ST_DONE : ST_BASE_WAIT;
            end
            ST_BASE_WAIT:
            begin
                if (mm_done)
                    state_next = ST_POW;
            end
            ST_POW:
            begin
                state_next = (e_reg == '0) ? ST_CHECK : ST_POW_WAIT;
            end
            ST_POW_WAIT:
            begin
                if (mm_done)
                    state_next = ST_POW;
            end
            ST_CHECK:
            begin
                if (m_reg == W'(1) || m_reg == n_m1)
                    state_next = ST_BASE;
                else
                    state_next = ST_SQ;
            end
            ST_SQ:
            begin
                state_next = (k_reg >= v_reg) ? ST_DONE : ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
            begin
                if (mm_done)
                    state_next = (mm_res == n_m1) ? ST_BASE : ST_SQ;
            end
            ST_DONE:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output logic
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        e_next     = e_reg;
        m_next     = m_reg;
        s_next     = s_reg;
        k_next     = k_reg;
        phase_next = phase_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        mm_ctl     = '0;
        mm_a       = m_reg;
        mm_b       = s_reg;
        mm_n       = n_reg;
        in_ready   = (state_reg == ST_IDLE) && !ov_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    n_next     = number;
                    count_next = (base_count_reg > CountW'(MaxBases)) ?
                                 CountW'(MaxBases) : base_count_reg;
                    idx_next   = '0;
                end
            end
            ST_TRIAL:
            begin
                // trial division: reduce n modulo the small prime
                mm_n = base_w;
                if (n_reg < W'(2))
                    res_next = 1'b0;
                else if (idx_reg >= count_reg)
                begin
                    u_next = n_m1;
                    v_next = '0;
                end
                else if (n_reg == base_w)
                    res_next = 1'b1;
                else
                begin
                    mm_ctl.start    = 1'b1;
                    mm_ctl.mode_mod = 1'b1;
                    mm_a            = n_reg;
                end
            end
            ST_TRIAL_WAIT:
            begin
                mm_a = n_reg;
                mm_n = base_w;
                if (mm_done)
                begin
                    res_next = 1'b0;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SPLIT:
            begin
                if (u_reg[0])
                    idx_next = '0;
                else
                begin
                    u_next = {1'b0, u_reg[W-1:1]};
                    v_next = v_reg + 1'b1;
                end
            end
            ST_BASE:
            begin
                if (idx_reg >= count_reg)
                    res_next = 1'b1;
                else
                begin
                    mm_ctl.start    = 1'b1;
                    mm_ctl.mode_mod = 1'b1;
                    mm_a            = base_w;
                end
            end
            ST_BASE_WAIT:
            begin
                if (mm_done)
                begin
                    s_next     = mm_res;
                    m_next     = W'(1);
                    e_next     = u_reg;
                    phase_next = 1'b0;
                    idx_next   = idx_reg + 1'b1;
                end
            end
            ST_POW:
            begin
                if (e_reg != '0)
                begin
                    mm_ctl.start = 1'b1;
                    if (!phase_reg && e_reg[0])
                        mm_a = m_reg;
                    else
                    begin
                        phase_next = 1'b1;
                        mm_a       = s_reg;
                    end
                    mm_b = s_reg;
                end
                k_next = VW'(1);
            end
            ST_POW_WAIT:
            begin
                if (mm_done)
                begin
                    if (!phase_reg)
                    begin
                        m_next     = mm_res;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        s_next     = mm_res;
                        e_next     = {1'b0, e_reg[W-1:1]};
                        phase_next = 1'b0;
                    end
                end
            end
            ST_SQ:
            begin
                if (k_reg >= v_reg)
                    res_next = 1'b0;
                else
                begin
                    mm_ctl.start = 1'b1;
                    mm_a         = m_reg;
                    mm_b         = m_reg;
                end
            end
            ST_SQ_WAIT:
            begin
                if (mm_done)
                begin
                    m_next = mm_res;
                    k_next = k_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        ov_next = (state_next == ST_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        idx_reg   <= idx_next;
        n_reg     <= n_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        e_reg     <= e_next;
        m_reg     <= m_next;
        s_reg     <= s_next;
        k_reg     <= k_next;
        phase_reg <= phase_next;
        res_reg   <= res_next;
    end

    assign out_valid = (state_reg == ST_DONE);
    assign is_prime  = res_reg;

endmodule

### tb/miller_rabin_primality_test_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_primality_test_core_tb: self-checking bench for the MR core
// Sends numbers through a valid/ready channel and predicts each verdict from
// a behavioral Miller-Rabin test that uses the current base count. Random
// stalls on both sides. Several base counts are used, including 0, 10 and 15.
// ----------------------------------------------------------------------------
module miller_rabin_primality_test_core_tb;
    import mrpt_pkg::*;

    localparam int NW        = 31;
    localparam int StallMax  = 18;
    localparam int WdogLimit = 400000;
    localparam int TailWait  = 40000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CountW-1:0] cfg_wdata;
    logic              in_valid;
    logic              in_ready;
    logic [NW-1:0]     number;
    logic              out_valid;
    logic              out_ready;
    logic              is_prime;

    logic [CountW-1:0] base_count_q;
    logic              verdict_q[$];
    int                errors;
    int                idle_cycles;
    int                rx_gap;
    bit                calm;

    miller_rabin_primality_test_core #(.NUMBER_WIDTH(NW)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .number    (number),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_prime  (is_prime)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Behavioral Miller-Rabin over the first cnt small primes
    function automatic logic predict_prime(input logic [NW-1:0] n_in,
                                           input logic [CountW-1:0] cnt_in);
        int unsigned bases[10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
        longint unsigned n, odd_part, acc, sq, ex;
        int unsigned cnt, twos;
        bit found;
        n = n_in;
        cnt = (cnt_in > 10) ? 10 : cnt_in;
        if (n < 2)
            return 1'b0;
        for (int i = 0; i < cnt; i++)
        begin
            if (n == bases[i])
                return 1'b1;
            if (n % bases[i] == 0)
                return 1'b0;
        end
        odd_part = n - 1;
        twos = 0;
        while (odd_part[0] == 1'b0)
        begin
            odd_part >>= 1;
            twos++;
        end
        for (int i = 0; i < cnt; i++)
        begin
            acc = 1;
            sq = bases[i] % n;
            ex = odd_part;
            while (ex > 0)
            begin
                if (ex[0])
                    acc = (acc * sq) % n;
                sq = (sq * sq) % n;
                ex >>= 1;
            end
            if (acc != 1 && acc != n - 1)
            begin
                found = 0;
                for (int k = 1; k < twos; k++)
                begin
                    acc = (acc * acc) % n;
                    if (acc == n - 1)
                    begin
                        found = 1;
                        break;
                    end
                end
                if (!found)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Send one word; optional random gap before it
    task automatic send_number(input logic [NW-1:0] n);
        if (!calm && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, StallMax)) @(posedge clk);
        verdict_q.insert(verdict_q.size(), predict_prime(n, base_count_q));
        in_valid <= 1'b1;
        number   <= n;
        do @(posedge clk); while (!in_ready);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (TailWait) @(posedge clk);
    endtask

    // Write base count while the core is idle
    task automatic set_base_count(input logic [CountW-1:0] cnt);
        drain();
        cfg_we       <= 1'b1;
        cfg_wdata    <= cnt;
        base_count_q  = cnt;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random odd-heavy number, small half of the time
    function automatic logic [NW-1:0] random_number();
        logic [NW-1:0] n;
        case ($urandom_range(0, 3))
            0:       n = NW'($urandom_range(1, 1000));
            1:       n = NW'($urandom_range(1, 100000) | 1);
            2:       n = NW'($urandom()) | 31'h1;
            default: n = NW'($urandom());
        endcase
        if (n == 0)
            n = 31'd1;
        return n;
    endfunction

    // Receiver: bounded random stalls, compare against oldest expectation
    always @(posedge clk)
    begin
        logic exp_v;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("is_prime: unexpected word, actual %0b", is_prime);
                    errors++;
                end
                else
                begin
                    exp_v = verdict_q.pop_front();
                    if (is_prime !== exp_v)
                    begin
                        $error("is_prime: expected %0b actual %0b", exp_v, is_prime);
                        errors++;
                    end
                end
            end
            if (calm || rx_gap == 1)
            begin
                out_ready <= 1'b1;
                rx_gap    <= 0;
            end
            else if (rx_gap > 1)
                rx_gap <= rx_gap - 1;
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                rx_gap    <= $urandom_range(1, StallMax);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no handshake while verdicts are pending
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || verdict_q.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WdogLimit)
        begin
            $display("miller_rabin_primality_test_core: mismatch");
            $finish;
        end
    end

    task automatic test_edges();
        send_number(31'd1);
        send_number(31'd2);
        send_number(31'd3);
        send_number(31'd4);
        send_number(31'd29);
        send_number(31'd31);
        send_number(31'd561);
        send_number(31'd2047);
        send_number(31'd1373653);
        send_number(31'h7FFFFFFF);
        send_number(31'h7FFFFFFE);
        send_number(31'h55555555);
        send_number(31'h2AAAAAAA);
        send_number(31'd2147483629);
    endtask

    task automatic test_counts();
        set_base_count(4'd0);
        send_number(31'd1);
        send_number(31'd9);
        send_number(31'h7FFFFFFF);
        set_base_count(4'd1);
        send_number(31'd2047);
        send_number(31'd2);
        send_number(31'd3);
        set_base_count(4'd15);
        send_number(31'd29);
        send_number(31'd25326001);
        set_base_count(4'd4);
        send_number(31'd1067548103);
        send_number(31'd97);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 25 == 24)
                set_base_count(CountW'($urandom_range(0, 15)));
            send_number(random_number());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        number       = '0;
        out_ready    = 1'b0;
        errors       = 0;
        idle_cycles  = 0;
        rx_gap       = 0;
        calm         = 0;
        base_count_q = 4'd10;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edges();
        test_counts();
        set_base_count(4'd10);
        test_random(75);
        calm = 1;
        test_random(15);
        drain();
        if (errors == 0)
            $display("miller_rabin_primality_test_core: match");
        else
            $display("miller_rabin_primality_test_core: mismatch");
        $finish;
    end

endmodule
